### src/bbsm_pkg.sv
// Package with the shared types, constants and codes of the band sort and merge block.
package bbsm_pkg;

    localparam int MAX_BANDS = 64;
    localparam int FILL_W    = $clog2(MAX_BANDS + 1);
    localparam logic [1:0] POL_MULTI = 2'd3;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_DONE   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_FLUSH
    } state_t;

    // One stored band.
    typedef struct packed {
        logic [3:0]  res;
        logic [15:0] start_bin;
        logic [15:0] span;
        logic [1:0]  pol;
        logic        excess;
        logic [15:0] pulses;
        logic [15:0] triplets;
        logic [15:0] max_pulses;
        logic [15:0] max_triplets;
    } band_t;

    // Control that every cell of the chain sees.
    typedef struct packed {
        logic insert;
        logic walk;
    } cell_ctl_t;

    // Control from the sequencer to the merge unit.
    typedef struct packed {
        logic take;
        logic first;
        logic flush;
    } merge_ctl_t;

endpackage

### src/bbsm_cell.sv
// One cell of the sorted chain: holds a band, shifts right on insert, left on walk.
module bbsm_cell (
    input  logic               clk,
    input  bbsm_pkg::cell_ctl_t ctl,
    input  logic               valid,
    input  bbsm_pkg::band_t    new_band,
    input  bbsm_pkg::band_t    left_band,
    input  logic               left_gt,
    input  bbsm_pkg::band_t    right_band,
    output bbsm_pkg::band_t    band,
    output logic               gt
);

    bbsm_pkg::band_t band_reg;
    bbsm_pkg::band_t band_next;

    // A held band with a strictly larger key moves aside for the new band.
    assign gt = valid && ({band_reg.res, band_reg.start_bin} >
                          {new_band.res, new_band.start_bin});

    // Next content of the cell.
    always_comb
    begin
        band_next = band_reg;
        if (ctl.insert)
        begin
            if (left_gt)
                band_next = left_band;
            else if (gt || !valid)
                band_next = new_band;
        end
        else if (ctl.walk)
        begin
            band_next = right_band;
        end
    end

    always_ff @(posedge clk)
    begin
        band_reg <= band_next;
    end

    assign band = band_reg;

endmodule

### src/bbsm_merge.sv
// Merge unit: folds bands from the head of the chain and emits merged results.
module bbsm_merge (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bbsm_pkg::merge_ctl_t ctl,
    input  bbsm_pkg::band_t      band,
    input  logic                 overflow_in,
    output logic                 out_valid,
    output logic [3:0]           out_res,
    output logic [16:0]          center_bin,
    output logic [15:0]          out_span,
    output logic [1:0]           out_pol,
    output logic [15:0]          out_pulses,
    output logic [15:0]          out_triplets,
    output logic [15:0]          out_max_pulses,
    output logic [15:0]          out_max_triplets,
    output logic                 out_excess,
    output logic                 overflow,
    output logic                 last
);

    bbsm_pkg::band_t cur_reg, cur_next;
    logic [16:0]     width_reg, width_next;

    logic            valid_reg, valid_next;
    logic            last_reg, last_next;
    logic            ovf_reg, ovf_next;
    logic [3:0]      res_reg, res_next;
    logic [16:0]     center_reg, center_next;
    logic [15:0]     span_reg, span_next;
    logic [1:0]      pol_reg, pol_next;
    logic [15:0]     pulses_reg, pulses_next;
    logic [15:0]     trip_reg, trip_next;
    logic [15:0]     maxp_reg, maxp_next;
    logic [15:0]     maxt_reg, maxt_next;
    logic            exc_reg, exc_next;

    logic [17:0] cur_end;
    logic [17:0] new_end;
    logic [17:0] max_end;
    logic [16:0] pulse_sum;
    logic        mergeable;
    logic        emit;

    // Overlap test and the grown band.
    always_comb
    begin
        cur_end   = {2'b0, cur_reg.start_bin} + {1'b0, width_reg};
        new_end   = {2'b0, band.start_bin} + {2'b0, band.span};
        max_end   = (new_end > cur_end) ? new_end : cur_end;
        pulse_sum = {1'b0, cur_reg.pulses} + {1'b0, band.pulses};
        mergeable = !ctl.first && (band.res == cur_reg.res) &&
                    (cur_end >= {2'b0, band.start_bin});
        emit      = (ctl.take && !ctl.first && !mergeable) || ctl.flush;
    end

    // Current band update.
    always_comb
    begin
        cur_next   = cur_reg;
        width_next = width_reg;
        if (ctl.take)
        begin
            if (mergeable)
            begin
                width_next     = max_end[16:0] - {1'b0, cur_reg.start_bin};
                cur_next.pulses = pulse_sum[16] ? 16'hFFFF : pulse_sum[15:0];
                if (cur_reg.pol != band.pol)
                    cur_next.pol = bbsm_pkg::POL_MULTI;
                cur_next.excess = cur_reg.excess | band.excess;
            end
            else
            begin
                cur_next   = band;
                width_next = {1'b0, band.span};
            end
        end
    end

    // Result register.
    always_comb
    begin
        valid_next  = emit;
        last_next   = ctl.flush;
        ovf_next    = overflow_in;
        res_next    = cur_reg.res;
        center_next = {1'b0, cur_reg.start_bin} + {1'b0, width_reg[16:1]};
        span_next   = width_reg[16] ? 16'hFFFF : width_reg[15:0];
        pol_next    = cur_reg.pol;
        pulses_next = cur_reg.pulses;
        trip_next   = cur_reg.triplets;
        maxp_next   = cur_reg.max_pulses;
        maxt_next   = cur_reg.max_triplets;
        exc_next    = cur_reg.excess;
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        width_reg  <= width_next;
        ovf_reg    <= ovf_next;
        res_reg    <= res_next;
        center_reg <= center_next;
        span_reg   <= span_next;
        pol_reg    <= pol_next;
        pulses_reg <= pulses_next;
        trip_reg   <= trip_next;
        maxp_reg   <= maxp_next;
        maxt_reg   <= maxt_next;
        exc_reg    <= exc_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            last_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            last_reg  <= last_next;
        end
    end

    assign out_valid        = valid_reg;
    assign last             = last_reg;
    assign overflow         = ovf_reg;
    assign out_res          = res_reg;
    assign center_bin       = center_reg;
    assign out_span         = span_reg;
    assign out_pol          = pol_reg;
    assign out_pulses       = pulses_reg;
    assign out_triplets     = trip_reg;
    assign out_max_pulses   = maxp_reg;
    assign out_max_triplets = maxt_reg;
    assign out_excess       = exc_reg;

endmodule

### src/bad_band_sort_merge.sv
// Top level: chain of sorting cells, walk sequencer and merge unit.
// A record or clear transfer leaves busy low, so the next start is taken at once.
// A done transfer on N stored bands holds busy through the walk and flush states (not at all on
// an empty store): the chain shifts one band a cycle into the merge unit; results are registered.
// Results cannot be stalled; out_valid marks each one for a single cycle, last marks the final.
// Reset empties the store and clears the overflow flag; stored contents are not cleared.
module bad_band_sort_merge (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  opcode,
    input  logic [3:0]  res,
    input  logic [15:0] start_bin,
    input  logic [15:0] span,
    input  logic [1:0]  pol,
    input  logic [15:0] pulses,
    input  logic [15:0] triplets,
    input  logic [15:0] max_pulses,
    input  logic [15:0] max_triplets,
    input  logic        triplet_excess,
    output logic        out_valid,
    output logic [3:0]  out_res,
    output logic [16:0] center_bin,
    output logic [15:0] out_span,
    output logic [1:0]  out_pol,
    output logic [15:0] out_pulses,
    output logic [15:0] out_triplets,
    output logic [15:0] out_max_pulses,
    output logic [15:0] out_max_triplets,
    output logic        out_excess,
    output logic        overflow,
    output logic        last
);

    localparam int N  = bbsm_pkg::MAX_BANDS;
    localparam int FW = bbsm_pkg::FILL_W;

    bbsm_pkg::state_t     state_reg, state_next;
    logic [FW-1:0]        fill_reg, fill_next;
    logic [FW-1:0]        idx_reg, idx_next;
    logic                 ovf_reg, ovf_next;
    logic                 accept;
    bbsm_pkg::cell_ctl_t  cell_ctl;
    bbsm_pkg::merge_ctl_t merge_ctl;
    bbsm_pkg::band_t      new_band;
    bbsm_pkg::band_t      bands [N];
    logic [N-1:0]         gts;
    logic                 full;

    assign accept = start && !busy;
    assign full   = (fill_reg == FW'(N));

    always_comb
    begin
        new_band.res          = res;
        new_band.start_bin    = start_bin;
        new_band.span         = span;
        new_band.pol          = pol;
        new_band.excess       = triplet_excess;
        new_band.pulses       = pulses;
        new_band.triplets     = triplets;
        new_band.max_pulses   = max_pulses;
        new_band.max_triplets = max_triplets;
    end

    // Chain of cells.
    genvar g;
    generate
        for (g = 0; g < N; g++)
        begin : g_cell
            bbsm_pkg::band_t left_b;
            bbsm_pkg::band_t right_b;
            logic            left_g;
            if (g == 0)
            begin : g_head
                assign left_b = new_band;
                assign left_g = 1'b0;
            end
            else
            begin : g_mid
                assign left_b = bands[g-1];
                assign left_g = gts[g-1];
            end
            if (g == N - 1)
            begin : g_tail
                assign right_b = bands[g];
            end
            else
            begin : g_body
                assign right_b = bands[g+1];
            end
            bbsm_cell u_cell (
                .clk        (clk),
                .ctl        (cell_ctl),
                .valid      (FW'(g) < fill_reg),
                .new_band   (new_band),
                .left_band  (left_b),
                .left_gt    (left_g),
                .right_band (right_b),
                .band       (bands[g]),
                .gt         (gts[g])
            );
        end
    endgenerate

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bbsm_pkg::ST_IDLE:
            begin
                if (accept && opcode == bbsm_pkg::OP_DONE && fill_reg != '0)
                    state_next = bbsm_pkg::ST_WALK;
            end
            bbsm_pkg::ST_WALK:
            begin
                if (idx_reg == fill_reg - FW'(1))
                    state_next = bbsm_pkg::ST_FLUSH;
            end
            bbsm_pkg::ST_FLUSH:
            begin
                state_next = bbsm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = bbsm_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer and bookkeeping.
    always_comb
    begin
        fill_next       = fill_reg;
        idx_next        = idx_reg;
        ovf_next        = ovf_reg;
        cell_ctl.insert = 1'b0;
        cell_ctl.walk   = 1'b0;
        merge_ctl.take  = 1'b0;
        merge_ctl.first = 1'b0;
        merge_ctl.flush = 1'b0;
        unique case (state_reg)
            bbsm_pkg::ST_IDLE:
            begin
                idx_next = '0;
                if (accept)
                begin
                    unique case (opcode)
                        bbsm_pkg::OP_RECORD:
                        begin
                            if (full)
                                ovf_next = 1'b1;
                            else
                            begin
                                cell_ctl.insert = 1'b1;
                                fill_next       = fill_reg + FW'(1);
                            end
                        end
                        bbsm_pkg::OP_CLEAR:
                        begin
                            fill_next = '0;
                            ovf_next  = 1'b0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            bbsm_pkg::ST_WALK:
            begin
                cell_ctl.walk   = 1'b1;
                merge_ctl.take  = 1'b1;
                merge_ctl.first = (idx_reg == '0);
                idx_next        = idx_reg + FW'(1);
            end
            bbsm_pkg::ST_FLUSH:
            begin
                merge_ctl.flush = 1'b1;
                fill_next       = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bbsm_pkg::ST_IDLE;
            fill_reg  <= '0;
            idx_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            idx_reg   <= idx_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign busy = (state_reg != bbsm_pkg::ST_IDLE);

    // Merge unit at the head of the chain.
    bbsm_merge u_merge (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (merge_ctl),
        .band             (bands[0]),
        .overflow_in      (ovf_reg),
        .out_valid        (out_valid),
        .out_res          (out_res),
        .center_bin       (center_bin),
        .out_span         (out_span),
        .out_pol          (out_pol),
        .out_pulses       (out_pulses),
        .out_triplets     (out_triplets),
        .out_max_pulses   (out_max_pulses),
        .out_max_triplets (out_max_triplets),
        .out_excess       (out_excess),
        .overflow         (overflow),
        .last             (last)
    );

    // The store never holds more than its capacity.
    assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= FW'(N))
        else $error("fill count beyond capacity");

    // A flush always leaves the store empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bbsm_pkg::ST_FLUSH |=> fill_reg == '0)
        else $error("store not emptied after done");

    // The final result follows in the cycle after the flush.
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bbsm_pkg::ST_FLUSH |=> out_valid && last)
        else $error("missing final result");

    // Results come only from a done: each one follows a walk or flush state.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> $past(state_reg) != bbsm_pkg::ST_IDLE)
        else $error("result outside a done");

endmodule
